/* design/aes_pkg.sv */
// AES package: state machine type, register indexes, S-box tables and round functions.
// Used by aes_block_cipher and its testbench. No other dependencies.
package aes_pkg;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXPAND,
    ST_RUN,
    ST_HOLD
  } aes_state_t;

  localparam logic [2:0] REG_KEY0    = 3'd0;
  localparam logic [2:0] REG_KEY1    = 3'd1;
  localparam logic [2:0] REG_KEY2    = 3'd2;
  localparam logic [2:0] REG_KEY3    = 3'd3;
  localparam logic [2:0] REG_KEY_LEN = 3'd4;

  localparam logic [1:0] KEY_LEN_128 = 2'd0;
  localparam logic [1:0] KEY_LEN_192 = 2'd1;

  localparam logic [7:0] SBOX [256] = '{
    8'h63, 8'h7c, 8'h77, 8'h7b, 8'hf2, 8'h6b, 8'h6f, 8'hc5,
    8'h30, 8'h01, 8'h67, 8'h2b, 8'hfe, 8'hd7, 8'hab, 8'h76,
    8'hca, 8'h82, 8'hc9, 8'h7d, 8'hfa, 8'h59, 8'h47, 8'hf0,
    8'had, 8'hd4, 8'ha2, 8'haf, 8'h9c, 8'ha4, 8'h72, 8'hc0,
    8'hb7, 8'hfd, 8'h93, 8'h26, 8'h36, 8'h3f, 8'hf7, 8'hcc,
    8'h34, 8'ha5, 8'he5, 8'hf1, 8'h71, 8'hd8, 8'h31, 8'h15,
    8'h04, 8'hc7, 8'h23, 8'hc3, 8'h18, 8'h96, 8'h05, 8'h9a,
    8'h07, 8'h12, 8'h80, 8'he2, 8'heb, 8'h27, 8'hb2, 8'h75,
    8'h09, 8'h83, 8'h2c, 8'h1a, 8'h1b, 8'h6e, 8'h5a, 8'ha0,
    8'h52, 8'h3b, 8'hd6, 8'hb3, 8'h29, 8'he3, 8'h2f, 8'h84,
    8'h53, 8'hd1, 8'h00, 8'hed, 8'h20, 8'hfc, 8'hb1, 8'h5b,
    8'h6a, 8'hcb, 8'hbe, 8'h39, 8'h4a, 8'h4c, 8'h58, 8'hcf,
    8'hd0, 8'hef, 8'haa, 8'hfb, 8'h43, 8'h4d, 8'h33, 8'h85,
    8'h45, 8'hf9, 8'h02, 8'h7f, 8'h50, 8'h3c, 8'h9f, 8'ha8,
    8'h51, 8'ha3, 8'h40, 8'h8f, 8'h92, 8'h9d, 8'h38, 8'hf5,
    8'hbc, 8'hb6, 8'hda, 8'h21, 8'h10, 8'hff, 8'hf3, 8'hd2,
    8'hcd, 8'h0c, 8'h13, 8'hec, 8'h5f, 8'h97, 8'h44, 8'h17,
    8'hc4, 8'ha7, 8'h7e, 8'h3d, 8'h64, 8'h5d, 8'h19, 8'h73,
    8'h60, 8'h81, 8'h4f, 8'hdc, 8'h22, 8'h2a, 8'h90, 8'h88,
    8'h46, 8'hee, 8'hb8, 8'h14, 8'hde, 8'h5e, 8'h0b, 8'hdb,
    8'he0, 8'h32, 8'h3a, 8'h0a, 8'h49, 8'h06, 8'h24, 8'h5c,
    8'hc2, 8'hd3, 8'hac, 8'h62, 8'h91, 8'h95, 8'he4, 8'h79,
    8'he7, 8'hc8, 8'h37, 8'h6d, 8'h8d, 8'hd5, 8'h4e, 8'ha9,
    8'h6c, 8'h56, 8'hf4, 8'hea, 8'h65, 8'h7a, 8'hae, 8'h08,
    8'hba, 8'h78, 8'h25, 8'h2e, 8'h1c, 8'ha6, 8'hb4, 8'hc6,
    8'he8, 8'hdd, 8'h74, 8'h1f, 8'h4b, 8'hbd, 8'h8b, 8'h8a,
    8'h70, 8'h3e, 8'hb5, 8'h66, 8'h48, 8'h03, 8'hf6, 8'h0e,
    8'h61, 8'h35, 8'h57, 8'hb9, 8'h86, 8'hc1, 8'h1d, 8'h9e,
    8'he1, 8'hf8, 8'h98, 8'h11, 8'h69, 8'hd9, 8'h8e, 8'h94,
    8'h9b, 8'h1e, 8'h87, 8'he9, 8'hce, 8'h55, 8'h28, 8'hdf,
    8'h8c, 8'ha1, 8'h89, 8'h0d, 8'hbf, 8'he6, 8'h42, 8'h68,
    8'h41, 8'h99, 8'h2d, 8'h0f, 8'hb0, 8'h54, 8'hbb, 8'h16
  };

  localparam logic [7:0] INV_SBOX [256] = '{
    8'h52, 8'h09, 8'h6a, 8'hd5, 8'h30, 8'h36, 8'ha5, 8'h38,
    8'hbf, 8'h40, 8'ha3, 8'h9e, 8'h81, 8'hf3, 8'hd7, 8'hfb,
    8'h7c, 8'he3, 8'h39, 8'h82, 8'h9b, 8'h2f, 8'hff, 8'h87,
    8'h34, 8'h8e, 8'h43, 8'h44, 8'hc4, 8'hde, 8'he9, 8'hcb,
    8'h54, 8'h7b, 8'h94, 8'h32, 8'ha6, 8'hc2, 8'h23, 8'h3d,
    8'hee, 8'h4c, 8'h95, 8'h0b, 8'h42, 8'hfa, 8'hc3, 8'h4e,
    8'h08, 8'h2e, 8'ha1, 8'h66, 8'h28, 8'hd9, 8'h24, 8'hb2,
    8'h76, 8'h5b, 8'ha2, 8'h49, 8'h6d, 8'h8b, 8'hd1, 8'h25,
    8'h72, 8'hf8, 8'hf6, 8'h64, 8'h86, 8'h68, 8'h98, 8'h16,
    8'hd4, 8'ha4, 8'h5c, 8'hcc, 8'h5d, 8'h65, 8'hb6, 8'h92,
    8'h6c, 8'h70, 8'h48, 8'h50, 8'hfd, 8'hed, 8'hb9, 8'hda,
    8'h5e, 8'h15, 8'h46, 8'h57, 8'ha7, 8'h8d, 8'h9d, 8'h84,
    8'h90, 8'hd8, 8'hab, 8'h00, 8'h8c, 8'hbc, 8'hd3, 8'h0a,
    8'hf7, 8'he4, 8'h58, 8'h05, 8'hb8, 8'hb3, 8'h45, 8'h06,
    8'hd0, 8'h2c, 8'h1e, 8'h8f, 8'hca, 8'h3f, 8'h0f, 8'h02,
    8'hc1, 8'haf, 8'hbd, 8'h03, 8'h01, 8'h13, 8'h8a, 8'h6b,
    8'h3a, 8'h91, 8'h11, 8'h41, 8'h4f, 8'h67, 8'hdc, 8'hea,
    8'h97, 8'hf2, 8'hcf, 8'hce, 8'hf0, 8'hb4, 8'he6, 8'h73,
    8'h96, 8'hac, 8'h74, 8'h22, 8'he7, 8'had, 8'h35, 8'h85,
    8'he2, 8'hf9, 8'h37, 8'he8, 8'h1c, 8'h75, 8'hdf, 8'h6e,
    8'h47, 8'hf1, 8'h1a, 8'h71, 8'h1d, 8'h29, 8'hc5, 8'h89,
    8'h6f, 8'hb7, 8'h62, 8'h0e, 8'haa, 8'h18, 8'hbe, 8'h1b,
    8'hfc, 8'h56, 8'h3e, 8'h4b, 8'hc6, 8'hd2, 8'h79, 8'h20,
    8'h9a, 8'hdb, 8'hc0, 8'hfe, 8'h78, 8'hcd, 8'h5a, 8'hf4,
    8'h1f, 8'hdd, 8'ha8, 8'h33, 8'h88, 8'h07, 8'hc7, 8'h31,
    8'hb1, 8'h12, 8'h10, 8'h59, 8'h27, 8'h80, 8'hec, 8'h5f,
    8'h60, 8'h51, 8'h7f, 8'ha9, 8'h19, 8'hb5, 8'h4a, 8'h0d,
    8'h2d, 8'he5, 8'h7a, 8'h9f, 8'h93, 8'hc9, 8'h9c, 8'hef,
    8'ha0, 8'he0, 8'h3b, 8'h4d, 8'hae, 8'h2a, 8'hf5, 8'hb0,
    8'hc8, 8'heb, 8'hbb, 8'h3c, 8'h83, 8'h53, 8'h99, 8'h61,
    8'h17, 8'h2b, 8'h04, 8'h7e, 8'hba, 8'h77, 8'hd6, 8'h26,
    8'he1, 8'h69, 8'h14, 8'h63, 8'h55, 8'h21, 8'h0c, 8'h7d
  };

  function automatic logic [7:0] xtime(input logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [31:0] sub_word(input logic [31:0] w);
    return {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
  endfunction

  // Byte 0 of a block sits in bits 127:120.
  function automatic logic [7:0] get_byte(input logic [127:0] b, input int i);
    return b[127-8*i -: 8];
  endfunction

  function automatic logic [31:0] mix_col(input logic [31:0] c);
    logic [7:0] a0, a1, a2, a3;
    a0 = c[31:24]; a1 = c[23:16]; a2 = c[15:8]; a3 = c[7:0];
    return {xtime(a0) ^ xtime(a1) ^ a1 ^ a2 ^ a3,
            a0 ^ xtime(a1) ^ xtime(a2) ^ a2 ^ a3,
            a0 ^ a1 ^ xtime(a2) ^ xtime(a3) ^ a3,
            xtime(a0) ^ a0 ^ a1 ^ a2 ^ xtime(a3)};
  endfunction

  function automatic logic [31:0] inv_mix_col(input logic [31:0] c);
    logic [7:0] a [4];
    logic [7:0] m9 [4];
    logic [7:0] mb [4];
    logic [7:0] md [4];
    logic [7:0] me [4];
    logic [7:0] x2, x4, x8;
    a[0] = c[31:24]; a[1] = c[23:16]; a[2] = c[15:8]; a[3] = c[7:0];
    for (int k = 0; k < 4; k++) begin
      x2 = xtime(a[k]);
      x4 = xtime(x2);
      x8 = xtime(x4);
      m9[k] = x8 ^ a[k];
      mb[k] = x8 ^ x2 ^ a[k];
      md[k] = x8 ^ x4 ^ a[k];
      me[k] = x8 ^ x4 ^ x2;
    end
    return {me[0] ^ mb[1] ^ md[2] ^ m9[3],
            m9[0] ^ me[1] ^ mb[2] ^ md[3],
            md[0] ^ m9[1] ^ me[2] ^ mb[3],
            mb[0] ^ md[1] ^ m9[2] ^ me[3]};
  endfunction

  // SubBytes, ShiftRows, then MixColumns unless last.
  function automatic logic [127:0] enc_round(input logic [127:0] s, input logic last);
    logic [127:0] t;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        t[127-8*(c*4+r) -: 8] = SBOX[get_byte(s, ((c + r) % 4) * 4 + r)];
      end
    end
    if (!last) begin
      for (int c = 0; c < 4; c++) begin
        t[127-32*c -: 32] = mix_col(t[127-32*c -: 32]);
      end
    end
    return t;
  endfunction

  // InvShiftRows and InvSubBytes.
  function automatic logic [127:0] dec_sub(input logic [127:0] s);
    logic [127:0] t;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        t[127-8*(((c + r) % 4) * 4 + r) -: 8] = INV_SBOX[get_byte(s, c*4+r)];
      end
    end
    return t;
  endfunction

  function automatic logic [127:0] dec_mix(input logic [127:0] s);
    logic [127:0] t;
    for (int c = 0; c < 4; c++) begin
      t[127-32*c -: 32] = inv_mix_col(s[127-32*c -: 32]);
    end
    return t;
  endfunction

endpackage

/* design/aes_block_cipher.sv */
// AES-128/192/256 block cipher core with on-chip key expansion and round-key store.
// Depends on aes_pkg (tables, round functions, state type).
//
//  channel | dir | handshake            | payload
//  in      | in  | in_tvalid/in_tready  | in_tuser = kind, in_tdata = block_high, block_low
//  out     | out | out_tvalid/out_tready| out_tdata = out_high, out_low
//  cfg     | in  | APB psel/penable     | 64-bit key words and key length at 8*i
//
// A block runs through ST_RUN, one round per cycle through the shared round unit
// (Nr = 10, 12 or 14 rounds), one round key read per cycle, then waits in ST_HOLD
// until the result register is free; no new block is taken before it has left ST_HOLD.
// Each key register write starts key expansion: one 32-bit word per cycle until all
// round keys are stored, during which no block is taken. Reset is synchronous, active
// low; the round-key store holds garbage until the first key write. A new block
// is taken while a result still waits on out_tready; the core stalls only if
// the result register is still full when the next block finishes.
module aes_block_cipher
  import aes_pkg::*;
#(
  parameter int ROUND_KEY_SLOTS = 15
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [127:0] in_tdata,     // [63:0] block_high, [127:64] block_low
  input  logic         in_tuser,     // [0] kind: 0 encrypt, 1 decrypt
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [127:0] out_tdata,    // [63:0] out_high, [127:64] out_low
  input  logic         cfg_psel,
  input  logic         cfg_penable,
  input  logic         cfg_pwrite,
  input  logic [5:0]   cfg_paddr,
  input  logic [63:0]  cfg_pwdata,
  output logic [63:0]  cfg_prdata,
  output logic         cfg_pready
);

  localparam int AW = $clog2(ROUND_KEY_SLOTS);
  localparam int IW = $clog2(4 * ROUND_KEY_SLOTS);
  localparam logic [3:0] NR_MAX = 4'(ROUND_KEY_SLOTS - 1);

  aes_state_t state_r, state_nxt;

  logic [63:0]  key_r [4];
  logic [1:0]   key_len_r;
  logic [127:0] store [ROUND_KEY_SLOTS];
  logic [127:0] rk_q;
  logic [AW-1:0] rd_addr;

  logic [31:0]  win_r [8];
  logic [127:0] row_r, row_nxt;
  logic [IW-1:0] widx_r, widx_nxt;
  logic [2:0]   kmod_r, kmod_nxt;
  logic [7:0]   rc_r, rc_nxt;
  logic [31:0]  new_word;

  logic [127:0] st_r, st_nxt;
  logic [3:0]   step_r, step_nxt;
  logic         kind_r;
  logic         out_valid_r;
  logic [127:0] out_r;

  logic [2:0] nk;
  logic [3:0] nr;
  logic [2:0] cfg_idx;
  logic       cfg_wr, key_wr, in_acc, out_free, exp_last;

  assign cfg_pready = 1'b1;
  assign cfg_idx    = cfg_paddr[5:3];
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite;
  assign key_wr     = cfg_wr && (cfg_idx <= REG_KEY_LEN);
  assign in_acc     = in_tvalid & in_tready;
  assign out_free   = !out_valid_r || out_tready;

  always_comb begin
    case (key_len_r)
      KEY_LEN_128: nk = 3'd4;
      KEY_LEN_192: nk = 3'd6;
      default:     nk = 3'd0;   // 8 words, wraps in 3 bits; handled below
    endcase
  end

  // Nk + 6, capped by the store depth
  always_comb begin
    logic [3:0] full_nr;
    case (key_len_r)
      KEY_LEN_128: full_nr = 4'd10;
      KEY_LEN_192: full_nr = 4'd12;
      default:     full_nr = 4'd14;
    endcase
    nr = (full_nr > NR_MAX) ? NR_MAX : full_nr;
  end

  // register file
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_r[0]  <= '0;
      key_r[1]  <= '0;
      key_r[2]  <= '0;
      key_r[3]  <= '0;
      key_len_r <= KEY_LEN_128;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_KEY0:    key_r[0]  <= cfg_pwdata;
        REG_KEY1:    key_r[1]  <= cfg_pwdata;
        REG_KEY2:    key_r[2]  <= cfg_pwdata;
        REG_KEY3:    key_r[3]  <= cfg_pwdata;
        REG_KEY_LEN: key_len_r <= cfg_pwdata[1:0];
        default:     ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_KEY0:    cfg_prdata = key_r[0];
      REG_KEY1:    cfg_prdata = key_r[1];
      REG_KEY2:    cfg_prdata = key_r[2];
      REG_KEY3:    cfg_prdata = key_r[3];
      REG_KEY_LEN: cfg_prdata = {62'd0, key_len_r};
      default:     cfg_prdata = '0;
    endcase
  end

  // key expansion datapath: one word per cycle
  always_comb begin
    logic [31:0] t, back;
    logic        wide, first_pass;
    wide       = (nk == 3'd0);
    first_pass = wide ? (widx_r < IW'(8)) : (widx_r < IW'(nk));
    back       = wide ? win_r[7] : win_r[nk - 3'd1];
    t          = win_r[0];
    if (kmod_r == 3'd0) begin
      t = sub_word({t[23:0], t[31:24]}) ^ {rc_r, 24'd0};
    end else if (wide && kmod_r == 3'd4) begin
      t = sub_word(t);
    end
    if (first_pass) begin
      new_word = widx_r[0] ? key_r[widx_r[2:1]][31:0] : key_r[widx_r[2:1]][63:32];
    end else begin
      new_word = back ^ t;
    end
    row_nxt  = {row_r[95:0], new_word};
    widx_nxt = widx_r + IW'(1);
    kmod_nxt = (wide ? (kmod_r == 3'd7) : (kmod_r == nk - 3'd1)) ? 3'd0 : kmod_r + 3'd1;
    rc_nxt   = (!first_pass && kmod_r == 3'd0) ? xtime(rc_r) : rc_r;
    exp_last = (widx_r == IW'({nr, 2'b11}));
  end

  always_ff @(posedge clk) begin
    if (key_wr) begin
      widx_r <= '0;
      kmod_r <= '0;
      rc_r   <= 8'h01;
    end else if (state_r == ST_EXPAND) begin
      widx_r <= widx_nxt;
      kmod_r <= kmod_nxt;
      rc_r   <= rc_nxt;
      row_r  <= row_nxt;
      win_r[0] <= new_word;
      for (int j = 1; j < 8; j++) begin
        win_r[j] <= win_r[j-1];
      end
    end
  end

  // round-key store
  always_ff @(posedge clk) begin
    if (state_r == ST_EXPAND && !key_wr && widx_r[1:0] == 2'b11) begin
      store[AW'(widx_r >> 2)] <= row_nxt;
    end
    rk_q <= store[rd_addr];
  end

  // address of the key used in the next cycle
  always_comb begin
    logic       k;
    logic [3:0] s;
    if (state_r == ST_IDLE) begin
      k = in_tuser;
      s = 4'd0;
    end else begin
      k = kind_r;
      s = step_r + 4'd1;
    end
    rd_addr = AW'(k ? (nr - s) : s);
  end

  // sequencer
  always_comb begin
    state_nxt = state_r;
    if (key_wr) begin
      state_nxt = ST_EXPAND;
    end else begin
      case (state_r)
        ST_IDLE:   if (in_tvalid) state_nxt = ST_RUN;
        ST_EXPAND: if (exp_last) state_nxt = ST_IDLE;
        ST_RUN:    if (step_r == nr) state_nxt = ST_HOLD;
        ST_HOLD:   if (out_free) state_nxt = ST_IDLE;
        default:   state_nxt = ST_IDLE;
      endcase
    end
  end

  always_comb begin
    logic [127:0] t;
    t         = '0;
    in_tready = (state_r == ST_IDLE);
    step_nxt  = step_r;
    st_nxt    = st_r;
    case (state_r)
      ST_IDLE: begin
        step_nxt = 4'd0;
        st_nxt   = {in_tdata[63:0], in_tdata[127:64]};
      end
      ST_RUN: begin
        step_nxt = step_r + 4'd1;
        if (step_r == 4'd0) begin
          st_nxt = st_r ^ rk_q;
        end else if (!kind_r) begin
          st_nxt = enc_round(st_r, step_r == nr) ^ rk_q;
        end else begin
          t      = dec_sub(st_r) ^ rk_q;
          st_nxt = (step_r == nr) ? t : dec_mix(t);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_HOLD && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    step_r <= step_nxt;
    st_r   <= st_nxt;
    if (in_acc) begin
      kind_r <= in_tuser;
    end
    if (state_r == ST_HOLD && out_free) begin
      out_r <= st_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_r[63:0], out_r[127:64]};

`ifndef SYNTHESIS
  a_no_ready_expand: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_EXPAND |-> !in_tready)
    else $error("input ready during key expansion");
  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && !key_wr |=> state_r == ST_RUN && step_r == 4'd0)
    else $error("accepted request did not start rounds");
  a_step_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_RUN |-> step_r <= nr)
    else $error("round counter past last round");
  a_cfg_restart: assert property (@(posedge clk) disable iff (!rst_n)
    key_wr |=> state_r == ST_EXPAND && widx_r == '0)
    else $error("key write did not restart expansion");
`endif

endmodule

/* test/aes_block_cipher_tb.sv */
// Self-checking testbench for aes_block_cipher: stream requests with random stalls,
// key setup over the APB-style port, results checked against an in-bench AES predictor.
// Depends on aes_pkg (register indexes) and the aes_block_cipher RTL.
`timescale 1ns / 1ps

module aes_block_cipher_tb;
  import aes_pkg::*;

  localparam logic KIND_ENC = 1'b0;
  localparam logic KIND_DEC = 1'b1;
  localparam logic [1:0] KEY_LEN_256 = 2'd2;
  localparam logic [1:0] KEY_LEN_ALT = 2'd3;  // code 3 behaves as a 256-bit key
  localparam int STALL_LIMIT = 5000;

  logic         clk;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic [127:0] in_tdata;   // [63:0] block_high, [127:64] block_low
  logic         in_tuser;   // [0] kind
  logic         out_tvalid;
  logic         out_tready;
  logic [127:0] out_tdata;  // [63:0] out_high, [127:64] out_low
  logic         cfg_psel;
  logic         cfg_penable;
  logic         cfg_pwrite;
  logic [5:0]   cfg_paddr;
  logic [63:0]  cfg_pwdata;
  logic [63:0]  cfg_prdata;
  logic         cfg_pready;

  aes_block_cipher i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  always begin
    clk = 1'b1; #5;
    clk = 1'b0; #5;
  end

  // ---------------- predictor state ----------------
  logic [7:0]   fwd_sb [256];
  logic [7:0]   inv_sb [256];
  logic [127:0] pred_rkeys [15];
  logic [63:0]  key_w [4];
  logic [1:0]   key_len;

  logic [127:0] cipher_q [$];  // expected {high, low} per accepted block
  int           errors;
  int           idle_cycles;

  function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] acc;
    acc = 8'h00;
    for (int k = 0; k < 8; k++) begin
      if (b[0]) acc ^= a;
      a = a[7] ? ({a[6:0], 1'b0} ^ 8'h1b) : {a[6:0], 1'b0};
      b = b >> 1;
    end
    return acc;
  endfunction

  function automatic logic [7:0] rotl(input logic [7:0] v, input int n);
    return (v << n) | (v >> (8 - n));
  endfunction

  task automatic build_sboxes();
    logic [7:0] inv, base, s;
    int e;
    for (int x = 0; x < 256; x++) begin
      inv = 8'h01;
      base = x[7:0];
      if (x == 0) begin
        inv = 8'h00;
      end else begin
        e = 254;
        while (e != 0) begin
          if (e & 1) inv = gf_mul(inv, base);
          base = gf_mul(base, base);
          e = e >> 1;
        end
      end
      s = inv ^ rotl(inv, 1) ^ rotl(inv, 2) ^ rotl(inv, 3) ^ rotl(inv, 4) ^ 8'h63;
      fwd_sb[x] = s;
      inv_sb[s] = x[7:0];
    end
  endtask

  function automatic int round_count();
    int nk;
    nk = (key_len == 2'd0) ? 4 : (key_len == 2'd1) ? 6 : 8;
    return (nk + 6 > 14) ? 14 : nk + 6;
  endfunction

  task automatic expand_round_keys();
    logic [7:0] w [240];
    logic [7:0] t [4];
    logic [7:0] first, rc;
    int nk, nr, total;
    nk = (key_len == 2'd0) ? 4 : (key_len == 2'd1) ? 6 : 8;
    nr = round_count();
    total = 4 * (nr + 1);
    for (int i = 0; i < 240; i++) w[i] = 8'h00;
    for (int i = 0; i < nk * 4; i++) w[i] = key_w[i / 8][63 - 8 * (i % 8) -: 8];
    for (int i = nk; i < total; i++) begin
      for (int j = 0; j < 4; j++) t[j] = w[(i - 1) * 4 + j];
      if (i % nk == 0) begin
        first = t[0];
        t[0] = t[1]; t[1] = t[2]; t[2] = t[3]; t[3] = first;
        for (int j = 0; j < 4; j++) t[j] = fwd_sb[t[j]];
        rc = 8'h01;
        for (int k = 1; k < i / nk; k++) rc = gf_mul(rc, 8'h02);
        t[0] ^= rc;
      end else if (nk > 6 && i % nk == 4) begin
        for (int j = 0; j < 4; j++) t[j] = fwd_sb[t[j]];
      end
      for (int j = 0; j < 4; j++) w[i * 4 + j] = w[(i - nk) * 4 + j] ^ t[j];
    end
    for (int r = 0; r <= nr; r++)
      for (int b = 0; b < 16; b++) pred_rkeys[r][127 - 8 * b -: 8] = w[r * 16 + b];
  endtask

  function automatic logic [127:0] pred_sub(input logic [127:0] s, input logic inv);
    for (int i = 0; i < 16; i++)
      s[127 - 8 * i -: 8] = inv ? inv_sb[s[127 - 8 * i -: 8]] : fwd_sb[s[127 - 8 * i -: 8]];
    return s;
  endfunction

  function automatic logic [127:0] pred_shift(input logic [127:0] s, input logic inv);
    logic [127:0] t;
    int other;
    t = s;
    for (int c = 0; c < 4; c++)
      for (int r = 0; r < 4; r++) begin
        other = ((c + r) % 4) * 4 + r;
        if (inv) s[127 - 8 * other -: 8] = t[127 - 8 * (c * 4 + r) -: 8];
        else     s[127 - 8 * (c * 4 + r) -: 8] = t[127 - 8 * other -: 8];
      end
    return s;
  endfunction

  function automatic logic [127:0] pred_mix(input logic [127:0] s, input logic inv);
    logic [7:0] fm [4];
    logic [7:0] im [4];
    logic [127:0] t;
    logic [7:0] v;
    fm = '{8'h02, 8'h03, 8'h01, 8'h01};
    im = '{8'h0e, 8'h0b, 8'h0d, 8'h09};
    for (int c = 0; c < 4; c++)
      for (int r = 0; r < 4; r++) begin
        v = 8'h00;
        for (int k = 0; k < 4; k++)
          v ^= gf_mul(inv ? im[(k - r + 4) % 4] : fm[(k - r + 4) % 4],
                      s[127 - 8 * (c * 4 + k) -: 8]);
        t[127 - 8 * (c * 4 + r) -: 8] = v;
      end
    return t;
  endfunction

  function automatic logic [127:0] aes_predict(input logic kind, input logic [127:0] blk);
    int nr;
    nr = round_count();
    if (kind == KIND_ENC) begin
      blk ^= pred_rkeys[0];
      for (int r = 1; r < nr; r++)
        blk = pred_mix(pred_shift(pred_sub(blk, 1'b0), 1'b0), 1'b0) ^ pred_rkeys[r];
      blk = pred_shift(pred_sub(blk, 1'b0), 1'b0) ^ pred_rkeys[nr];
    end else begin
      blk ^= pred_rkeys[nr];
      for (int r = nr - 1; r > 0; r--)
        blk = pred_mix(pred_sub(pred_shift(blk, 1'b1), 1'b1) ^ pred_rkeys[r], 1'b1);
      blk = pred_sub(pred_shift(blk, 1'b1), 1'b1) ^ pred_rkeys[0];
    end
    return blk;
  endfunction

  // ---------------- drivers ----------------
  task automatic wait_drain();
    in_tvalid <= 1'b0;
    while (cipher_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [63:0] value);
    wait_drain();
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 3'b000};
    cfg_pwdata  <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    if (idx == REG_KEY_LEN) key_len = value[1:0];
    else key_w[idx] = value;
    expand_round_keys();
  endtask

  task automatic load_key(input logic [63:0] k0, k1, k2, k3, input logic [1:0] len);
    write_reg(REG_KEY0, k0);
    write_reg(REG_KEY1, k1);
    write_reg(REG_KEY2, k2);
    write_reg(REG_KEY3, k3);
    write_reg(REG_KEY_LEN, {62'd0, len});
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  task automatic send_block(input logic kind, input logic [63:0] hi, input logic [63:0] lo,
                            input bit gaps);
    int gap;
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= {lo, hi};
    do @(posedge clk); while (!in_tready);
    cipher_q.push_back(aes_predict(kind, {hi, lo}));
    gap = 0;
    if (gaps) gap = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 60) : $urandom_range(0, 2);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // ---------------- result side ----------------
  int stall_left;
  always @(posedge clk) begin
    int pick;
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_tready <= 1'b0;
    end else begin
      pick = $urandom_range(0, 99);
      out_tready <= (pick < 70);
      if (pick >= 97) stall_left <= $urandom_range(20, 60);
      else if (pick >= 70) stall_left <= $urandom_range(0, 3);
    end
  end

  always @(posedge clk) begin
    logic [127:0] want;
    if (rst_n && out_tvalid && out_tready) begin
      if (cipher_q.size() == 0) begin
        $display("%0t: unexpected result %h", $time, out_tdata);
        errors++;
      end else begin
        want = cipher_q.pop_front();
        if (out_tdata[63:0] !== want[127:64]) begin
          $display("%0t: out_high expected %h actual %h", $time, want[127:64], out_tdata[63:0]);
          errors++;
        end
        if (out_tdata[127:64] !== want[63:0]) begin
          $display("%0t: out_low expected %h actual %h", $time, want[63:0], out_tdata[127:64]);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("%0t: timeout with %0d results pending", $time, cipher_q.size());
      $display("FAIL");
      $finish;
    end
  end

  // ---------------- tests ----------------
  task automatic test_fips_vectors();
    load_key(64'h0001020304050607, 64'h08090a0b0c0d0e0f, 64'h1011121314151617,
             64'h18191a1b1c1d1e1f, KEY_LEN_128);
    send_block(KIND_ENC, 64'h0011223344556677, 64'h8899aabbccddeeff, 1'b0);
    send_block(KIND_DEC, 64'h69c4e0d86a7b0430, 64'hd8cdb78070b4c55a, 1'b0);
    write_reg(REG_KEY_LEN, {62'd0, KEY_LEN_192});
    send_block(KIND_ENC, 64'h0011223344556677, 64'h8899aabbccddeeff, 1'b0);
    send_block(KIND_DEC, 64'hdda97ca4864cdfe0, 64'h6eaf70a0ec0d7191, 1'b0);
    write_reg(REG_KEY_LEN, {62'd0, KEY_LEN_256});
    send_block(KIND_ENC, 64'h0011223344556677, 64'h8899aabbccddeeff, 1'b0);
    send_block(KIND_DEC, 64'h8ea2b7ca516745bf, 64'heafc49904b496089, 1'b0);
  endtask

  task automatic test_extremes();
    logic [1:0] lens [4];
    lens = '{KEY_LEN_128, KEY_LEN_192, KEY_LEN_256, KEY_LEN_ALT};
    load_key('0, '0, '0, '0, KEY_LEN_128);
    send_block(KIND_ENC, '0, '0, 1'b0);
    send_block(KIND_DEC, '0, '0, 1'b0);
    load_key('1, '1, '1, '1, KEY_LEN_256);
    send_block(KIND_ENC, '1, '1, 1'b0);
    send_block(KIND_DEC, '1, '1, 1'b0);
    for (int i = 0; i < 4; i++) begin
      write_reg(REG_KEY_LEN, {62'd0, lens[i]});
      send_block(KIND_ENC, '1, '0, 1'b0);
      send_block(KIND_DEC, '0, '1, 1'b0);
    end
    // back-to-back blocks with no gap
    send_block(KIND_ENC, 64'h8000000000000001, 64'h0000000000000080, 1'b0);
    send_block(KIND_DEC, 64'h0123456789abcdef, 64'hfedcba9876543210, 1'b0);
  endtask

  task automatic test_random_keys(input int settings, input int per_setting);
    logic [1:0] len;
    for (int s = 0; s < settings; s++) begin
      len = 2'($urandom_range(0, 3));
      load_key(rand64(), rand64(), rand64(), rand64(), len);
      for (int n = 0; n < per_setting; n++) begin
        // some blocks are encrypt-then-decrypt pairs of the same data
        if ($urandom_range(0, 3) == 0) begin
          logic [63:0] hi, lo;
          hi = rand64();
          lo = rand64();
          send_block(KIND_ENC, hi, lo, 1'b1);
          send_block(KIND_DEC, hi, lo, 1'b1);
          n++;
        end else begin
          send_block(1'($urandom_range(0, 1)), rand64(), rand64(),
                     $urandom_range(0, 7) != 0);
        end
      end
      in_tvalid <= 1'b0;
    end
  endtask

  initial begin
    errors = 0;
    idle_cycles = 0;
    stall_left = 0;
    key_len = '0;
    for (int i = 0; i < 4; i++) key_w[i] = '0;
    for (int i = 0; i < 15; i++) pred_rkeys[i] = '0;
    build_sboxes();
    rst_n       <= 1'b0;
    in_tvalid   <= 1'b0;
    in_tuser    <= 1'b0;
    in_tdata    <= '0;
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    cfg_paddr   <= '0;
    cfg_pwdata  <= '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_fips_vectors();
    in_tvalid <= 1'b0;
    test_extremes();
    in_tvalid <= 1'b0;
    test_random_keys(8, 185);

    wait_drain();
    repeat (30) @(posedge clk);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

/* files.f */
design/aes_pkg.sv
design/aes_block_cipher.sv
test/aes_block_cipher_tb.sv
